/* rtl/pctk_pkg.sv */
`timescale 1ns / 1ps
package pctk_pkg;
  localparam int unsigned IdxW = 16;
  localparam int unsigned ValW = 32;
  localparam int unsigned RankW = 5;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegNeighboursKept = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMinValue = 2'd1;
  localparam logic [CfgIdxW-1:0] RegKeepDiagonal = 2'd2;

  typedef struct packed {
    logic [IdxW-1:0]        column_index;
    logic [IdxW-1:0]        row_index;
    logic signed [ValW-1:0] entry_value;
    logic                   is_finite;
    logic                   column_end;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0]        out_column;
    logic [IdxW-1:0]        out_row;
    logic signed [ValW-1:0] out_value;
    logic [RankW-1:0]       out_rank;
    logic                   out_last;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    logic                   keep;
    logic                   col_end;
    logic [IdxW-1:0]        column;
    logic [IdxW-1:0]        row;
    logic signed [ValW-1:0] value;
  } cmd_t;
endpackage

/* rtl/pctk_front.sv */
`timescale 1ns / 1ps
module pctk_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [pctk_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  output logic [pctk_pkg::RankW-1:0]     nk_o,
  input  pctk_pkg::in_item_t             in_i,
  output pctk_pkg::cmd_t                 cmd_o
);
  logic [pctk_pkg::RankW-1:0] nk_q;
  logic signed [pctk_pkg::ValW-1:0] min_q;
  logic diag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nk_q <= 5'd16;
      min_q <= '0;
      diag_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pctk_pkg::RegNeighboursKept: nk_q <= cfg_data_i[pctk_pkg::RankW-1:0];
        pctk_pkg::RegMinValue:       min_q <= cfg_data_i[pctk_pkg::ValW-1:0];
        pctk_pkg::RegKeepDiagonal:   diag_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign nk_o = nk_q;
  always_comb begin
    cmd_o.keep = in_i.is_finite && (in_i.entry_value >= min_q) &&
                 ((in_i.row_index != in_i.column_index) || diag_q);
    cmd_o.col_end = in_i.column_end;
    cmd_o.column = in_i.column_index;
    cmd_o.row = in_i.row_index;
    cmd_o.value = in_i.entry_value;
  end
endmodule

/* rtl/pctk_queue.sv */
`timescale 1ns / 1ps
module pctk_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pctk_pkg::cmd_t data_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output pctk_pkg::cmd_t data_o
);
  pctk_pkg::cmd_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end
  assign data_o = mem_q[rp_q];
  assign valid_o = cnt_q != 2'd0;
  assign full_o = cnt_q == 2'd2;
endmodule

/* rtl/pctk_back.sv */
`timescale 1ns / 1ps
module pctk_back #(
  parameter int unsigned MaxN = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [pctk_pkg::RankW-1:0]  nk_i,
  input  logic                        valid_i,
  input  pctk_pkg::cmd_t              cmd_i,
  output logic                        pop_o,
  output logic                        idle_o,
  output logic                        out_valid_o,
  output pctk_pkg::out_item_t         out_o
);
  localparam int unsigned CW = $clog2(MaxN + 1);
  localparam int unsigned IW = $clog2(MaxN > 1 ? MaxN : 2);
  typedef enum logic {StRun, StEmit} state_e;
  state_e state_q;
  logic signed [pctk_pkg::ValW-1:0] val_q [MaxN];
  logic [pctk_pkg::IdxW-1:0] row_q [MaxN];
  logic [CW-1:0] cnt_q, n_q, ei_q;
  logic [pctk_pkg::IdxW-1:0] col_q;
  logic [CW-1:0] lim;
  logic [CW-1:0] cnt_c, cnt_ins, n_c;
  logic [IW-1:0] lim_ix;
  logic [MaxN-1:0] ge;
  logic ins_ok;

  always_comb begin
    if (nk_i == '0) lim = CW'(1);
    else if (32'(nk_i) > MaxN) lim = CW'(MaxN);
    else lim = CW'(nk_i);
    cnt_c = (cnt_q > lim) ? lim : cnt_q;
    for (int i = 0; i < MaxN; i++) begin
      ge[i] = (CW'(i) < cnt_c) && (val_q[i] >= cmd_i.value);
    end
    lim_ix = IW'(lim - CW'(1));
    ins_ok = cmd_i.keep && !(ge[lim_ix] && (cnt_c == lim));
    // a dropped entry leaves the list length untouched
    if (!cmd_i.keep) cnt_ins = cnt_q;
    else if (ins_ok && (cnt_c < lim)) cnt_ins = cnt_c + CW'(1);
    else cnt_ins = cnt_c;
    n_c = (cnt_ins > lim) ? lim : cnt_ins;
  end

  assign pop_o = valid_i && (state_q == StRun);
  assign idle_o = (state_q == StRun) && !valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StRun;
      cnt_q <= '0;
      n_q <= '0;
      ei_q <= '0;
      out_valid_o <= 1'b0;
    end else begin
      out_valid_o <= 1'b0;
      unique case (state_q)
        StRun: begin
          if (valid_i) begin
            cnt_q <= cnt_ins;
            if (cmd_i.col_end) begin
              cnt_q <= '0;
              n_q <= n_c;
              ei_q <= '0;
              if (n_c != '0) state_q <= StEmit;
            end
          end
        end
        StEmit: begin
          out_valid_o <= 1'b1;
          ei_q <= ei_q + CW'(1);
          if (ei_q + CW'(1) == n_q) state_q <= StRun;
        end
        default: state_q <= StRun;
      endcase
    end
  end

  // insertion shift network: entries below the slot move down by one
  always_ff @(posedge clk_i) begin
    if (state_q == StRun && pop_o && ins_ok) begin
      for (int i = 0; i < MaxN; i++) begin
        if (!ge[i]) begin
          if (i == 0 || ge[(i == 0) ? 0 : i - 1]) begin
            val_q[i] <= cmd_i.value;
            row_q[i] <= cmd_i.row;
          end else begin
            val_q[i] <= val_q[(i == 0) ? 0 : i - 1];
            row_q[i] <= row_q[(i == 0) ? 0 : i - 1];
          end
        end
      end
    end
    if (state_q == StRun && pop_o && cmd_i.col_end) col_q <= cmd_i.column;
    if (state_q == StEmit) begin
      out_o.out_column <= col_q;
      out_o.out_row <= row_q[ei_q[$clog2(MaxN > 1 ? MaxN : 2)-1:0]];
      out_o.out_value <= val_q[ei_q[$clog2(MaxN > 1 ? MaxN : 2)-1:0]];
      out_o.out_rank <= pctk_pkg::RankW'(ei_q + CW'(1));
      out_o.out_last <= (ei_q + CW'(1) == n_q);
    end
  end

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(MaxN))
    else $error("count overflow");
  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StEmit |-> n_q != '0) else $error("empty emit");
  a_nopop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StEmit |-> !pop_o) else $error("pop while emitting");
endmodule

/* rtl/per_column_threshold_top_k.sv */
`timescale 1ns / 1ps
// Streaming per-column top-k selector. Entries are taken one per cycle while
// start is high and busy is low; a column-end entry is followed by one result
// per kept entry, one per cycle, during which busy holds off input (the
// sorted register list is read out serially). Results cannot be stalled.
// Configuration writes wait while an item is queued for the back end.
module per_column_threshold_top_k #(
  parameter int unsigned MAX_NEIGHBOURS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  pctk_pkg::in_item_t           in_item_i,
  output logic                         strobe,
  output pctk_pkg::out_item_t          out_item_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [pctk_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                  cfg_data_i
);
  pctk_pkg::cmd_t fcmd, qcmd;
  logic [pctk_pkg::RankW-1:0] nk;
  logic full, qvalid, pop, idle, acc, emitting_q, cfg_we;

  assign cfg_ready_o = !qvalid;
  assign cfg_we = cfg_valid_i && cfg_ready_o;
  // hold input while the queue is full or results are pending
  assign busy = full || emitting_q;
  assign acc = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) emitting_q <= 1'b0;
    else emitting_q <= (acc && in_item_i.column_end) || (emitting_q && !idle);
  end

  pctk_front u_front (
    .clk_i, .rst_ni, .cfg_valid_i(cfg_we), .cfg_index_i, .cfg_data_i, .nk_o(nk),
    .in_i(in_item_i), .cmd_o(fcmd)
  );
  pctk_queue u_queue (
    .clk_i, .rst_ni, .push_i(acc), .data_i(fcmd), .full_o(full),
    .valid_o(qvalid), .pop_i(pop), .data_o(qcmd)
  );
  pctk_back #(.MaxN(MAX_NEIGHBOURS)) u_back (
    .clk_i, .rst_ni, .nk_i(nk), .valid_i(qvalid), .cmd_i(qcmd), .pop_o(pop),
    .idle_o(idle), .out_valid_o(strobe), .out_o(out_item_o)
  );
endmodule

/* sim/tb_per_column_threshold_top_k.sv */
`timescale 1ns / 1ps
module tb_per_column_threshold_top_k;
  localparam logic [pctk_pkg::CfgIdxW-1:0] RegUnused = 2'd3;

  class topk_scoreboard;
    logic [4:0] kept_len_reg;
    logic signed [31:0] floor_reg;
    logic diag_reg;
    logic signed [31:0] list_vals[16];
    logic [15:0] list_rows[16];
    int list_cnt;
    pctk_pkg::out_item_t pending_q[$];
    int errors;
    int items_seen;
    int results_seen;

    function new();
      kept_len_reg = 5'd16;
      floor_reg = 0;
      diag_reg = 0;
      list_cnt = 0;
      errors = 0;
      items_seen = 0;
      results_seen = 0;
    endfunction

    function void set_reg(logic [pctk_pkg::CfgIdxW-1:0] idx, logic [31:0] data);
      case (idx)
        pctk_pkg::RegNeighboursKept: kept_len_reg = data[4:0];
        pctk_pkg::RegMinValue: floor_reg = data;
        pctk_pkg::RegKeepDiagonal: diag_reg = data[0];
        default: ;
      endcase
    endfunction

    function int limit();
      int k;
      k = kept_len_reg;
      if (k < 1) k = 1;
      if (k > 16) k = 16;
      return k;
    endfunction

    function void note_item(pctk_pkg::in_item_t it);
      int k;
      int pos;
      int i;
      pctk_pkg::out_item_t r;
      items_seen++;
      k = limit();
      if (it.is_finite && it.entry_value >= floor_reg &&
          (it.row_index != it.column_index || diag_reg)) begin
        if (list_cnt > k) list_cnt = k;
        pos = 0;
        while (pos < list_cnt && list_vals[pos] >= it.entry_value) pos++;
        if (pos < k) begin
          i = (list_cnt < k) ? list_cnt : k - 1;
          while (i > pos) begin
            list_vals[i] = list_vals[i-1];
            list_rows[i] = list_rows[i-1];
            i--;
          end
          list_vals[pos] = it.entry_value;
          list_rows[pos] = it.row_index;
          if (list_cnt < k) list_cnt++;
        end
      end
      if (it.column_end) begin
        if (list_cnt > k) list_cnt = k;
        for (i = 0; i < list_cnt; i++) begin
          r.out_column = it.column_index;
          r.out_row = list_rows[i];
          r.out_value = list_vals[i];
          r.out_rank = 5'(i + 1);
          r.out_last = (i + 1 == list_cnt);
          pending_q = {pending_q, r};
        end
        list_cnt = 0;
      end
    endfunction

    function void check_result(pctk_pkg::out_item_t got);
      pctk_pkg::out_item_t exp;
      results_seen++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp = pending_q.pop_front();
      if (got.out_column !== exp.out_column)
        $display("%0t: out_column exp %0d got %0d", $time, exp.out_column, got.out_column);
      if (got.out_row !== exp.out_row)
        $display("%0t: out_row exp %0d got %0d", $time, exp.out_row, got.out_row);
      if (got.out_value !== exp.out_value)
        $display("%0t: out_value exp %0d got %0d", $time, exp.out_value, got.out_value);
      if (got.out_rank !== exp.out_rank)
        $display("%0t: out_rank exp %0d got %0d", $time, exp.out_rank, got.out_rank);
      if (got.out_last !== exp.out_last)
        $display("%0t: out_last exp %0d got %0d", $time, exp.out_last, got.out_last);
      if (got !== exp) errors++;
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic start = 0;
  logic busy;
  pctk_pkg::in_item_t in_item_i = '0;
  logic strobe;
  pctk_pkg::out_item_t out_item_o;
  logic cfg_valid_i = 0;
  logic cfg_ready_o;
  logic [pctk_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  topk_scoreboard topk_sb = new();
  int item_total = 0;

  per_column_threshold_top_k u_dut (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && strobe) topk_sb.check_result(out_item_o);
  end

  task automatic write_reg(logic [pctk_pkg::CfgIdxW-1:0] idx, logic [31:0] data);
    start <= 0;
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    topk_sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  task automatic send_item(pctk_pkg::in_item_t it, bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 12) : 0;
    if (w > 0) begin
      start <= 0;
      repeat (w) @(negedge clk_i);
    end
    start <= 1;
    in_item_i <= it;
    do @(posedge clk_i); while (busy);
    topk_sb.note_item(it);
    item_total++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    start <= 0;
    while (topk_sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  function automatic pctk_pkg::in_item_t mk(int c, int r, logic [31:0] v, bit f, bit e);
    pctk_pkg::in_item_t it;
    it.column_index = 16'(c);
    it.row_index = 16'(r);
    it.entry_value = v;
    it.is_finite = f;
    it.column_end = e;
    return it;
  endfunction

  task automatic random_column(int len, bit gaps);
    int c;
    int r;
    logic [31:0] v;
    c = $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 20);
    r = $urandom_range(0, 3);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 5))
        0: v = $urandom;
        1: v = $urandom_range(0, 3) << 16;
        default: v = $urandom_range(0, 32'h0004_0000) - 32'h0001_0000;
      endcase
      if ($urandom_range(0, 9) == 0) r = c;
      else if ($urandom_range(0, 15) == 0) r = $urandom;
      send_item(mk(c, r, v, $urandom_range(0, 9) != 0, i == len - 1), gaps);
      r = r + $urandom_range(1, 3);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    send_item(mk(3, 1, 32'h7fff_ffff, 1, 0), 0);
    send_item(mk(3, 3, 32'h0002_0000, 1, 0), 0);
    send_item(mk(3, 4, 32'h8000_0000, 1, 0), 0);
    send_item(mk(3, 5, 32'h0001_0000, 0, 0), 0);
    send_item(mk(3, 6, 32'h7fff_ffff, 1, 0), 0);
    send_item(mk(3, 7, 32'h0000_0000, 1, 1), 0);
    send_item(mk(9, 0, 32'hffff_ffff, 1, 1), 0);
    send_item(mk(16'hffff, 16'hffff, 32'h0001_0000, 1, 1), 0);
    drain();
    write_reg(pctk_pkg::RegKeepDiagonal, 1);
    write_reg(pctk_pkg::RegMinValue, 32'h8000_0000);
    write_reg(pctk_pkg::RegNeighboursKept, 0);
    send_item(mk(5, 5, 32'h8000_0000, 1, 0), 0);
    send_item(mk(5, 6, 32'h0000_0001, 1, 0), 0);
    send_item(mk(7, 7, 32'h0000_0001, 1, 1), 0);
    drain();
    write_reg(pctk_pkg::RegNeighboursKept, 31);
    write_reg(RegUnused, 32'hffff_ffff);
    for (int i = 0; i < 18; i++) send_item(mk(2, i, i % 5, 1, 0), 0);
    write_reg(pctk_pkg::RegNeighboursKept, 3);
    send_item(mk(2, 20, 32'h7fff_ffff, 1, 1), 0);
    drain();

    while (item_total < 335) begin
      write_reg(pctk_pkg::RegNeighboursKept,
                $urandom_range(0, 5) == 0 ? $urandom : $urandom_range(1, 6));
      write_reg(pctk_pkg::RegMinValue, $urandom_range(0, 3) == 0 ? $urandom :
                $urandom_range(0, 32'h0002_0000) - 32'h0001_0000);
      write_reg(pctk_pkg::RegKeepDiagonal, $urandom);
      for (int c = 0; c < 6; c++) random_column($urandom_range(1, 12), $urandom_range(0, 3) != 0);
      drain();
    end

    drain();
    $display("%0d items sent, %0d results checked over random thresholds and list lengths",
             item_total, topk_sb.results_seen);
    if (topk_sb.errors == 0 && topk_sb.pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end
endmodule

/* files.f */
rtl/pctk_pkg.sv
rtl/pctk_front.sv
rtl/pctk_queue.sv
rtl/pctk_back.sv
rtl/per_column_threshold_top_k.sv
sim/tb_per_column_threshold_top_k.sv
